@@ rtl/b32c_pkg.sv @@
// shared types, constants and the symbol table of the crockford base32 decoder
package b32c_pkg;

    // message byte counter width and its saturation value
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // configuration and field widths
    localparam int LIMIT_W = 16;
    localparam int CMP_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int SYM_W   = 8;
    localparam int VAL_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;

    // output limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // one classified symbol as it travels from front to back
    typedef struct packed {
        logic             bad;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_cls;

    // crockford table: case-insensitive, O as 0, I and L as 1, U invalid
    function automatic t_cls classify(input logic [SYM_W-1:0] c, input logic last);
        logic [SYM_W-1:0] u;
        t_cls             r;
        u       = c;
        r.bad   = 1'b0;
        r.value = '0;
        r.last  = last;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - 8'h20;
        end
        unique case (u)
            8'h30: r.value = 5'd0;
            8'h31: r.value = 5'd1;
            8'h32: r.value = 5'd2;
            8'h33: r.value = 5'd3;
            8'h34: r.value = 5'd4;
            8'h35: r.value = 5'd5;
            8'h36: r.value = 5'd6;
            8'h37: r.value = 5'd7;
            8'h38: r.value = 5'd8;
            8'h39: r.value = 5'd9;
            8'h41: r.value = 5'd10;
            8'h42: r.value = 5'd11;
            8'h43: r.value = 5'd12;
            8'h44: r.value = 5'd13;
            8'h45: r.value = 5'd14;
            8'h46: r.value = 5'd15;
            8'h47: r.value = 5'd16;
            8'h48: r.value = 5'd17;
            8'h49: r.value = 5'd1;
            8'h4A: r.value = 5'd18;
            8'h4B: r.value = 5'd19;
            8'h4C: r.value = 5'd1;
            8'h4D: r.value = 5'd20;
            8'h4E: r.value = 5'd21;
            8'h4F: r.value = 5'd0;
            8'h50: r.value = 5'd22;
            8'h51: r.value = 5'd23;
            8'h52: r.value = 5'd24;
            8'h53: r.value = 5'd25;
            8'h54: r.value = 5'd26;
            8'h56: r.value = 5'd27;
            8'h57: r.value = 5'd28;
            8'h58: r.value = 5'd29;
            8'h59: r.value = 5'd30;
            8'h5A: r.value = 5'd31;
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/b32c_front.sv @@
// front stage: accepts a character beat and registers its classification
module b32c_front
    import b32c_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_last,
    output logic             o_valid,
    output t_cls             o_item,
    input  logic             i_ready
);

    logic r_valid;
    t_cls r_item;

    // stage frees up when empty or when the queue takes its content
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // table lookup into the stage register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= classify(i_symbol, i_last);
        end
    end

endmodule

@@ rtl/b32c_fifo.sv @@
// short queue of classified symbols between front and back
module b32c_fifo
    import b32c_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_wr_item,
    output logic o_full,
    input  logic i_pop,
    output t_cls o_rd_item,
    output logic o_empty
);

    t_cls               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full    = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

`ifndef SYNTHESIS
    // fill count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("fifo count beyond depth");

    // no push into a full queue unless a pop frees a slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_full |-> i_pop)
        else $error("fifo overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("fifo underflow");
`endif

endmodule

@@ rtl/b32c_unpack.sv @@
// back stage: bit buffer, byte emission, limit, error flag and output register
module b32c_unpack
    import b32c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    input  t_cls               i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_data,
    output logic               o_byte_valid,
    output logic               o_bad,
    output logic               o_last
);

    logic [LIMIT_W-1:0]     r_limit;
    logic [PEND_W-1:0]      r_pend;
    logic [PCNT_W-1:0]      r_pcnt;
    logic                   r_err;
    logic [COUNT_WIDTH-1:0] r_bytes;

    logic [PEND_W-1:0]      n_pend;
    logic [PCNT_W-1:0]      n_pcnt;
    logic                   n_err;
    logic [COUNT_WIDTH-1:0] n_bytes;

    logic                   r_ovalid;
    logic [BYTE_W-1:0]      r_odata;
    logic                   r_obv;
    logic                   r_obad;
    logic                   r_olast;

    logic                   out_free;
    logic [PEND_W+VAL_W-1:0] acc;
    logic [PCNT_W:0]        total;
    logic [PCNT_W-1:0]      rem;
    logic [BYTE_W-1:0]      full_byte;
    logic                   limit_ok;
    logic                   have_byte;
    logic                   emit;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = i_valid && out_free;

    // append five bits and split off a byte when eight are ready
    assign acc       = {r_pend, i_item.value};
    assign total     = {1'b0, r_pcnt} + (PCNT_W+1)'(VAL_W);
    assign rem       = total[PCNT_W-1:0];
    assign full_byte = BYTE_W'(acc >> rem);
    assign limit_ok  = (CMP_W'(r_bytes) < CMP_W'(r_limit)) && (r_bytes < CNT_MAX);

    always_comb begin
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        n_err     = r_err;
        n_bytes   = r_bytes;
        have_byte = 1'b0;
        if (!r_err) begin
            if (i_item.bad) begin
                n_err = 1'b1;
            end else if (total >= (PCNT_W+1)'(BYTE_W)) begin
                n_pend = PEND_W'(acc) & PEND_W'((PEND_W'(1) << rem) - PEND_W'(1));
                n_pcnt = rem;
                if (limit_ok) begin
                    have_byte = 1'b1;
                    n_bytes   = r_bytes + COUNT_WIDTH'(1);
                end
            end else begin
                n_pend = PEND_W'(acc);
                n_pcnt = total[PCNT_W-1:0];
            end
        end
    end

    assign emit = have_byte || i_item.last;

    // output limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // message state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_pcnt  <= '0;
            r_err   <= 1'b0;
            r_bytes <= '0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_pend  <= '0;
                r_pcnt  <= '0;
                r_err   <= 1'b0;
                r_bytes <= '0;
            end else begin
                r_pend  <= n_pend;
                r_pcnt  <= n_pcnt;
                r_err   <= n_err;
                r_bytes <= n_bytes;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= o_pop && emit;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_odata <= have_byte ? full_byte : '0;
            r_obv   <= have_byte;
            r_obad  <= n_err;
            r_olast <= i_item.last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_data       = r_odata;
    assign o_byte_valid = r_obv;
    assign o_bad        = r_obad;
    assign o_last       = r_olast;

`ifndef SYNTHESIS
    // a byte never comes out of a message already marked bad
    a_byte_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_obv |-> !r_obad)
        else $error("byte emitted after bad symbol");

    // final character leaves a clean message state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> r_pcnt == '0 && !r_err && r_bytes == '0)
        else $error("message state not cleared");

    // the byte count only moves together with an emitted byte
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_item.last && !have_byte |=> $stable(r_bytes))
        else $error("byte count moved without a byte");
`endif

endmodule

@@ rtl/base32_crockford_decoder.sv @@
// an accepted character beat passes the front register, then the queue, then the output register
// throughput: one character per cycle while the output accepts beats; the table lookup in
// the front stage and the bit-buffer update in the back stage are each registered once
// a 4-entry queue between front and back absorbs output stalls
// reset: synchronous active-low i_rst_n clears all message state and sets
// the output limit to 65535; no clearing pass is needed
module base32_crockford_decoder
    import b32c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] symbol
    input  logic               i_s_axis_tlast,   // end_of_text
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]         o_m_axis_tuser,   // [0] byte_valid, [1] bad_symbol
    output logic               o_m_axis_tlast    // last
);

    logic front_valid;
    t_cls front_item;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_push;
    logic fifo_pop;
    t_cls fifo_item;
    logic back_bv;
    logic back_bad;

    // character classification
    b32c_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_symbol (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_valid  (front_valid),
        .o_item   (front_item),
        .i_ready  (!fifo_full)
    );

    assign fifo_push = front_valid && !fifo_full;

    // queue between the two halves
    b32c_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (fifo_push),
        .i_wr_item (front_item),
        .o_full    (fifo_full),
        .i_pop     (fifo_pop),
        .o_rd_item (fifo_item),
        .o_empty   (fifo_empty)
    );

    // bit buffer and result beat
    b32c_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (!fifo_empty),
        .i_item       (fifo_item),
        .o_pop        (fifo_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_byte_valid (back_bv),
        .o_bad        (back_bad),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {back_bad, back_bv};

endmodule
